// ===== rtl/vfc_pkg.sv =====
package vfc_pkg;

   // request kinds
   localparam logic [1:0] REQ_CELL_WR   = 2'd0;
   localparam logic [1:0] REQ_BORDER_WR = 2'd1;
   localparam logic [1:0] REQ_QUERY     = 2'd2;

   // border planes
   localparam logic [1:0] SIDE_LEFT    = 2'd0;
   localparam logic [1:0] SIDE_RIGHT   = 2'd1;
   localparam logic [1:0] SIDE_BACK    = 2'd2;
   localparam logic [1:0] SIDE_FORWARD = 2'd3;

   // face kinds, also the bit positions of the exposed-face mask
   localparam logic [2:0] FACE_TOP    = 3'd0;
   localparam logic [2:0] FACE_BOTTOM = 3'd1;
   localparam logic [2:0] FACE_LEFT   = 3'd2;
   localparam logic [2:0] FACE_RIGHT  = 3'd3;
   localparam logic [2:0] FACE_FRONT  = 3'd4;
   localparam logic [2:0] FACE_BACK   = 3'd5;

   localparam int FACE_COUNT = 6;

   // configuration register index
   localparam logic REG_NEIGHBOUR = 1'b0;

   typedef struct packed {
      logic [1:0] req_type;
      logic [3:0] pos_x;
      logic [7:0] pos_y;
      logic [3:0] pos_z;
      logic [1:0] border_side;
      logic [3:0] border_index;
      logic       solid;
   } vfc_req_type;

   typedef struct packed {
      logic [3:0] face_x;
      logic [7:0] face_y;
      logic [3:0] face_z;
      logic [2:0] face_kind;
      logic       top_covered;
      logic       last_face;
   } vfc_rsp_type;

   // one culled query handed from the read sequencer to the face emitter
   typedef struct packed {
      logic [3:0]            x;
      logic [7:0]            y;
      logic [3:0]            z;
      logic [FACE_COUNT-1:0] mask;
      logic                  above;
   } vfc_hand_type;

endpackage

// ===== rtl/vfc_emit.sv =====
module vfc_emit
   import vfc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         hand_valid,
   input  vfc_hand_type hand_data,
   output logic         hand_ready,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output vfc_rsp_type  rsp_data
);

   logic [FACE_COUNT-1:0] em_mask_ff;
   logic [FACE_COUNT-1:0] em_mask_in;
   vfc_hand_type          em_info_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   vfc_rsp_type           rsp_data_ff;
   logic [2:0]            pick;
   logic [FACE_COUNT-1:0] rest;
   logic                  out_free;
   logic                  emit;

   // lowest pending face goes first
   always_comb begin
      pick = FACE_TOP;
      for (int k = FACE_COUNT - 1; k >= 0; k--) begin
         if (em_mask_ff[k]) begin
            pick = 3'(k);
         end
      end
      rest = em_mask_ff;
      rest[pick] = 1'b0;
   end

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign emit       = out_free && (em_mask_ff != '0);
   assign hand_ready = (em_mask_ff == '0) || (emit && (rest == '0));

   always_comb begin
      em_mask_in = em_mask_ff;
      if (hand_valid && hand_ready) begin
         em_mask_in = hand_data.mask;
      end else if (emit) begin
         em_mask_in = rest;
      end
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         em_mask_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         em_mask_ff   <= em_mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (hand_valid && hand_ready) begin
         em_info_ff <= hand_data;
      end
      if (emit) begin
         rsp_data_ff.face_x      <= em_info_ff.x;
         rsp_data_ff.face_y      <= em_info_ff.y;
         rsp_data_ff.face_z      <= em_info_ff.z;
         rsp_data_ff.face_kind   <= pick;
         rsp_data_ff.top_covered <= (pick >= FACE_LEFT) && em_info_ff.above;
         rsp_data_ff.last_face   <= (rest == '0);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/voxel_face_culler_top.sv =====
// Writes can arrive every cycle while the sequencer idles or hands off and produce no
// transaction. A query reads the cell store in states RD_C, RD_D, RD_R and RD_B (two
// reads per cycle), then waits in PH_HAND until the emitter takes it. The next query
// is taken only then, so its reads overlap the emission of the last one's faces, one per
// cycle unless rsp_stall holds them. Reset clears control state and the neighbour
// register only; cell and border stores keep their contents and need writing.
module voxel_face_culler_top
   import vfc_pkg::*;
#(
   parameter int CHUNK_SIDE = 16,
   parameter int CHUNK_TALL = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  vfc_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output vfc_rsp_type rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int SW         = $clog2(CHUNK_SIDE);
   localparam int TW         = $clog2(CHUNK_TALL);
   localparam int CA_W       = 2 * SW + TW;
   localparam int BA_W       = 2 + TW + SW;
   localparam int CELL_DEPTH = 1 << CA_W;
   localparam int BRD_DEPTH  = 1 << BA_W;

   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_RD_C  = 3'd1;
   localparam logic [2:0] PH_RD_D  = 3'd2;
   localparam logic [2:0] PH_RD_R  = 3'd3;
   localparam logic [2:0] PH_RD_B  = 3'd4;
   localparam logic [2:0] PH_HAND  = 3'd5;

   logic                 cell_mem [0:CELL_DEPTH-1];
   logic                 brd_mem  [0:BRD_DEPTH-1];

   logic [3:0]           np_ff;
   logic [2:0]           phase_ff;
   logic [2:0]           phase_in;
   logic [3:0]           qx_ff;
   logic [7:0]           qy_ff;
   logic [3:0]           qz_ff;
   logic                 rd_a_ff;
   logic                 rd_b_ff;
   logic                 brd_ff;
   logic                 cap_center_ff;
   logic                 cap_up_ff;
   logic                 cap_down_ff;
   logic                 cap_left_ff;
   logic                 cap_blr_ff;
   logic                 cap_right_ff;
   logic                 cap_front_ff;
   logic                 cap_bfb_ff;

   logic                 req_acc;
   logic                 pos_in_range;
   logic                 brd_in_range;
   logic                 cell_we;
   logic                 brd_we;
   logic [CA_W-1:0]      cell_wa;
   logic [BA_W-1:0]      brd_wa;
   logic                 rd_en;
   logic                 brd_en;
   logic [CA_W-1:0]      ra_a;
   logic [CA_W-1:0]      ra_b;
   logic [BA_W-1:0]      ra_brd;
   logic [SW-1:0]        cx, cx_p1, cx_m1, cz, cz_p1, cz_m1;
   logic [TW-1:0]        cy, cy_p1, cy_m1;
   logic                 x_lo, x_hi, z_lo, z_hi, y_lo, y_hi;
   logic [1:0]           lr_side, fb_side;
   logic [FACE_COUNT-1:0] face_cover;
   logic                 above;
   logic                 hand_valid;
   logic                 hand_ready;
   vfc_hand_type         hand_data;
   logic                 csr_wr;

   // configuration
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && (paddr[2] == REG_NEIGHBOUR);
   assign prdata = (paddr[2] == REG_NEIGHBOUR) ? {28'd0, np_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         np_ff <= 4'd0;
      end else if (csr_wr) begin
         np_ff <= pwdata[3:0];
      end
   end

   // intake
   assign req_stall = !((phase_ff == PH_IDLE) || ((phase_ff == PH_HAND) && hand_ready));
   assign req_acc   = req_valid && !req_stall;

   assign pos_in_range = (32'(req_data.pos_x) < CHUNK_SIDE) &&
                         (32'(req_data.pos_y) < CHUNK_TALL) &&
                         (32'(req_data.pos_z) < CHUNK_SIDE);
   assign brd_in_range = (32'(req_data.pos_y) < CHUNK_TALL) &&
                         (32'(req_data.border_index) < CHUNK_SIDE);

   assign cell_we = req_acc && (req_data.req_type == REQ_CELL_WR) && pos_in_range;
   assign brd_we  = req_acc && (req_data.req_type == REQ_BORDER_WR) && brd_in_range;
   assign cell_wa = {SW'(req_data.pos_x), TW'(req_data.pos_y), SW'(req_data.pos_z)};
   assign brd_wa  = {req_data.border_side, TW'(req_data.pos_y), SW'(req_data.border_index)};

   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         PH_IDLE, PH_HAND: begin
            if (req_acc && (req_data.req_type == REQ_QUERY) && pos_in_range) begin
               phase_in = PH_RD_C;
            end else if (phase_ff == PH_HAND && hand_ready) begin
               phase_in = PH_IDLE;
            end
         end
         PH_RD_C: phase_in = PH_RD_D;
         PH_RD_D: phase_in = PH_RD_R;
         PH_RD_R: phase_in = PH_RD_B;
         PH_RD_B: phase_in = PH_HAND;
         default: phase_in = PH_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc && (req_data.req_type == REQ_QUERY)) begin
         qx_ff <= req_data.pos_x;
         qy_ff <= req_data.pos_y;
         qz_ff <= req_data.pos_z;
      end
   end

   // neighbour addressing
   assign cx    = SW'(qx_ff);
   assign cy    = TW'(qy_ff);
   assign cz    = SW'(qz_ff);
   assign cx_p1 = cx + SW'(1);
   assign cx_m1 = cx - SW'(1);
   assign cy_p1 = cy + TW'(1);
   assign cy_m1 = cy - TW'(1);
   assign cz_p1 = cz + SW'(1);
   assign cz_m1 = cz - SW'(1);

   assign x_lo = (qx_ff == 4'd0);
   assign x_hi = (32'(qx_ff) == CHUNK_SIDE - 1);
   assign z_lo = (qz_ff == 4'd0);
   assign z_hi = (32'(qz_ff) == CHUNK_SIDE - 1);
   assign y_lo = (qy_ff == 8'd0);
   assign y_hi = (32'(qy_ff) == CHUNK_TALL - 1);

   assign lr_side = x_lo ? SIDE_LEFT : SIDE_RIGHT;
   assign fb_side = z_lo ? SIDE_BACK : SIDE_FORWARD;

   always_comb begin
      rd_en  = 1'b0;
      brd_en = 1'b0;
      ra_a   = {cx, cy, cz};
      ra_b   = {cx, cy, cz};
      ra_brd = {lr_side, cy, cz};
      case (phase_ff)
         PH_RD_C: begin
            rd_en = 1'b1;
            ra_b  = {cx, cy_p1, cz};
         end
         PH_RD_D: begin
            rd_en  = 1'b1;
            brd_en = 1'b1;
            ra_a   = {cx, cy_m1, cz};
            ra_b   = {cx_m1, cy, cz};
         end
         PH_RD_R: begin
            rd_en  = 1'b1;
            brd_en = 1'b1;
            ra_a   = {cx_p1, cy, cz};
            ra_b   = {cx, cy, cz_m1};
            ra_brd = {fb_side, cy, cx};
         end
         PH_RD_B: begin
            rd_en = 1'b1;
            ra_a  = {cx, cy, cz_p1};
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   // cell store: one write, two reads
   always_ff @(posedge clock) begin
      if (cell_we) begin
         cell_mem[cell_wa] <= req_data.solid;
      end
      if (rd_en) begin
         rd_a_ff <= cell_mem[ra_a];
         rd_b_ff <= cell_mem[ra_b];
      end
   end

   // border store: one write, one read
   always_ff @(posedge clock) begin
      if (brd_we) begin
         brd_mem[brd_wa] <= req_data.solid;
      end
      if (brd_en) begin
         brd_ff <= brd_mem[ra_brd];
      end
   end

   // capture each read pair as the next pair issues
   always_ff @(posedge clock) begin
      case (phase_ff)
         PH_RD_D: begin
            cap_center_ff <= rd_a_ff;
            cap_up_ff     <= rd_b_ff;
         end
         PH_RD_R: begin
            cap_down_ff <= rd_a_ff;
            cap_left_ff <= rd_b_ff;
            cap_blr_ff  <= brd_ff;
         end
         PH_RD_B: begin
            cap_right_ff <= rd_a_ff;
            cap_front_ff <= rd_b_ff;
            cap_bfb_ff   <= brd_ff;
         end
         default: begin
            cap_center_ff <= cap_center_ff;
         end
      endcase
   end

   // back neighbour is still in the port A register during hand-off
   assign above = !y_hi && cap_up_ff;
   always_comb begin
      face_cover[FACE_TOP]    = above;
      face_cover[FACE_BOTTOM] = !y_lo && cap_down_ff;
      face_cover[FACE_LEFT]   = x_lo ? (np_ff[SIDE_LEFT] && cap_blr_ff) : cap_left_ff;
      face_cover[FACE_RIGHT]  = x_hi ? (np_ff[SIDE_RIGHT] && cap_blr_ff) : cap_right_ff;
      face_cover[FACE_FRONT]  = z_lo ? (np_ff[SIDE_BACK] && cap_bfb_ff) : cap_front_ff;
      face_cover[FACE_BACK]   = z_hi ? (np_ff[SIDE_FORWARD] && cap_bfb_ff) : rd_a_ff;
   end

   assign hand_valid      = (phase_ff == PH_HAND);
   assign hand_data.x     = qx_ff;
   assign hand_data.y     = qy_ff;
   assign hand_data.z     = qz_ff;
   assign hand_data.mask  = cap_center_ff ? ~face_cover : '0;
   assign hand_data.above = above;

   vfc_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .hand_valid (hand_valid),
      .hand_data  (hand_data),
      .hand_ready (hand_ready),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

import vfc_pkg::*;

class face_scoreboard;
   bit          cell_mem [0:65535];
   bit          border_mem [0:16383];
   logic [3:0]  present;
   vfc_rsp_type faces_due [$];
   int          errors;

   function new();
      present = '0;
      errors = 0;
   endfunction

   function bit edge_covered(logic [1:0] side, logic [7:0] y, logic [3:0] idx);
      return present[side] && border_mem[{side, y, idx}];
   endfunction

   // Update the stores, or queue the exposed faces of a solid cell.
   function void note_request(vfc_req_type req);
      logic [3:0]            x, z, x_lo, x_hi, z_lo, z_hi;
      logic [7:0]            y, y_up, y_dn;
      logic [FACE_COUNT-1:0] covered;
      logic                  above;
      int                    last_kind;
      vfc_rsp_type           face;
      x = req.pos_x;
      y = req.pos_y;
      z = req.pos_z;
      x_lo = x - 4'd1;
      x_hi = x + 4'd1;
      z_lo = z - 4'd1;
      z_hi = z + 4'd1;
      y_up = y + 8'd1;
      y_dn = y - 8'd1;
      case (req.req_type)
         REQ_CELL_WR: cell_mem[{x, y, z}] = req.solid;
         REQ_BORDER_WR: border_mem[{req.border_side, y, req.border_index}] = req.solid;
         REQ_QUERY: begin
            if (!cell_mem[{x, y, z}])
               return;
            // top and bottom of the chunk are never covered
            above = (y != 8'd255) && cell_mem[{x, y_up, z}];
            covered[FACE_TOP] = above;
            covered[FACE_BOTTOM] = (y != 8'd0) && cell_mem[{x, y_dn, z}];
            covered[FACE_LEFT] = (x == 4'd0) ? edge_covered(SIDE_LEFT, y, z)
                                             : cell_mem[{x_lo, y, z}];
            covered[FACE_RIGHT] = (x == 4'd15) ? edge_covered(SIDE_RIGHT, y, z)
                                               : cell_mem[{x_hi, y, z}];
            covered[FACE_FRONT] = (z == 4'd0) ? edge_covered(SIDE_BACK, y, x)
                                              : cell_mem[{x, y, z_lo}];
            covered[FACE_BACK] = (z == 4'd15) ? edge_covered(SIDE_FORWARD, y, x)
                                              : cell_mem[{x, y, z_hi}];
            last_kind = -1;
            for (int k = FACE_TOP; k <= FACE_BACK; k++)
               if (!covered[k])
                  last_kind = k;
            for (int k = FACE_TOP; k <= FACE_BACK; k++) begin
               if (!covered[k]) begin
                  face.face_x = x;
                  face.face_y = y;
                  face.face_z = z;
                  face.face_kind = 3'(k);
                  face.top_covered = (k >= FACE_LEFT) && above;
                  face.last_face = (k == last_kind);
                  faces_due = {faces_due, face};
               end
            end
         end
         default: ;
      endcase
   endfunction

   function void check_face(vfc_rsp_type got);
      vfc_rsp_type want;
      if (faces_due.size() == 0) begin
         errors++;
         $display("%0t: unexpected face x=%0d y=%0d z=%0d kind=%0d top=%0b last=%0b",
                  $time, got.face_x, got.face_y, got.face_z, got.face_kind,
                  got.top_covered, got.last_face);
         return;
      end
      want = faces_due.pop_front();
      if (got !== want) begin
         errors++;
         $display("%0t: face mismatch, expected x=%0d y=%0d z=%0d kind=%0d top=%0b last=%0b",
                  $time, want.face_x, want.face_y, want.face_z, want.face_kind,
                  want.top_covered, want.last_face);
         $display("%0t:                   actual x=%0d y=%0d z=%0d kind=%0d top=%0b last=%0b",
                  $time, got.face_x, got.face_y, got.face_z, got.face_kind,
                  got.top_covered, got.last_face);
      end
   endfunction
endclass

module tb_top;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int SETTLE_CYCLES = 24;
   localparam logic [2:0] NEIGHBOUR_ADDR = {REG_NEIGHBOUR, 2'b00};
   localparam logic [2:0] SPARE_ADDR = {!REG_NEIGHBOUR, 2'b00};
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   vfc_req_type req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   vfc_rsp_type rsp_data;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   face_scoreboard faces = new();

   bit         known_cell [0:65535];
   bit         known_border [0:16383];
   int         burst_left;
   int         max_gap;
   int         items_sent;
   logic [3:0] cx, cz;
   logic [7:0] cy;

   voxel_face_culler_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            faces.check_face(rsp_data);
         if (req_valid && !req_stall)
            faces.note_request(req_data);
      end
   end

   initial begin : stall_pattern
      int stall_pct;
      int span;
      rsp_stall = 1'b0;
      forever begin
         stall_pct = 30 * $urandom_range(0, 2);
         span = $urandom_range(40, 300);
         repeat (span) begin
            @(negedge clock);
            rsp_stall = ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("FAILURE");
      $finish;
   end

   function automatic logic coin(int pct);
      return $urandom_range(0, 99) < pct;
   endfunction

   function automatic int near(int c, int hi);
      int v;
      v = c - 2 + int'($urandom_range(0, 4));
      return (v < 0) ? 0 : (v > hi) ? hi : v;
   endfunction

   function automatic int pick_coord(int hi);
      case ($urandom_range(0, 2))
         0: return 0;
         1: return hi;
         default: return $urandom_range(0, hi);
      endcase
   endfunction

   // Present one transaction in the current burst, hold it until taken.
   task automatic send_item(input vfc_req_type item);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(max_gap, 0);
         repeat (gap) @(negedge clock);
         burst_left = $urandom_range(1, 12);
      end
      req_data = item;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      req_valid = 1'b0;
      burst_left--;
      if (item.req_type != REQ_UNUSED)
         items_sent++;
   endtask

   task automatic put_cell(input logic [3:0] x, input logic [7:0] y, input logic [3:0] z,
                           input logic s);
      vfc_req_type item;
      item = vfc_req_type'($urandom);
      item.req_type = REQ_CELL_WR;
      item.pos_x = x;
      item.pos_y = y;
      item.pos_z = z;
      item.solid = s;
      known_cell[{x, y, z}] = 1'b1;
      send_item(item);
   endtask

   task automatic put_border(input logic [1:0] side, input logic [7:0] y,
                             input logic [3:0] idx, input logic s);
      vfc_req_type item;
      item = vfc_req_type'($urandom);
      item.req_type = REQ_BORDER_WR;
      item.border_side = side;
      item.pos_y = y;
      item.border_index = idx;
      item.solid = s;
      known_border[{side, y, idx}] = 1'b1;
      send_item(item);
   endtask

   task automatic fill_cell(input logic [3:0] x, input logic [7:0] y, input logic [3:0] z);
      if (!known_cell[{x, y, z}])
         put_cell(x, y, z, coin(60));
   endtask

   task automatic fill_border(input logic [1:0] side, input logic [7:0] y,
                              input logic [3:0] idx);
      if (!known_border[{side, y, idx}])
         put_border(side, y, idx, coin(60));
   endtask

   // Load every cell and border cell the query may touch, wrapped ones too.
   task automatic query_cell(input logic [3:0] x, input logic [7:0] y, input logic [3:0] z);
      vfc_req_type item;
      fill_cell(x, y, z);
      fill_cell(x, y + 8'd1, z);
      fill_cell(x, y - 8'd1, z);
      fill_cell(x - 4'd1, y, z);
      fill_cell(x + 4'd1, y, z);
      fill_cell(x, y, z - 4'd1);
      fill_cell(x, y, z + 4'd1);
      fill_border(SIDE_LEFT, y, z);
      fill_border(SIDE_RIGHT, y, z);
      fill_border(SIDE_BACK, y, x);
      fill_border(SIDE_FORWARD, y, x);
      item = vfc_req_type'($urandom);
      item.req_type = REQ_QUERY;
      item.pos_x = x;
      item.pos_y = y;
      item.pos_z = z;
      send_item(item);
   endtask

   task automatic surround(input logic [3:0] x, input logic [7:0] y, input logic [3:0] z,
                           input logic s);
      put_cell(x, y + 8'd1, z, s);
      put_cell(x, y - 8'd1, z, s);
      put_cell(x - 4'd1, y, z, s);
      put_cell(x + 4'd1, y, z, s);
      put_cell(x, y, z - 4'd1, s);
      put_cell(x, y, z + 4'd1, s);
   endtask

   // Drain all faces, then give an air query or a write time to retire.
   task automatic settle();
      while (faces.faces_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] value);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = addr;
      pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      if (addr == NEIGHBOUR_ADDR)
         faces.present = value[3:0];
   endtask

   task automatic run_phase(input logic [3:0] present_val, input int budget);
      int          target;
      int          n;
      bit          fresh;
      logic [1:0]  side;
      vfc_req_type item;
      settle();
      csr_write(NEIGHBOUR_ADDR, 32'(present_val));
      max_gap = coin(50) ? 6 : 0;
      target = items_sent + budget;
      fresh = 1'b1;
      while (items_sent < target) begin
         if (fresh || $urandom_range(0, 15) == 0) begin
            cx = 4'(pick_coord(15));
            cy = 8'(pick_coord(255));
            cz = 4'(pick_coord(15));
            fresh = 1'b0;
         end
         if ($urandom_range(0, 9) < 7) begin
            // writes around a cluster, then a query inside it
            n = $urandom_range(0, 4);
            repeat (n) begin
               if ($urandom_range(0, 3) == 0) begin
                  side = 2'($urandom);
                  put_border(side, 8'(near(cy, 255)),
                             (side < SIDE_BACK) ? 4'(near(cz, 15)) : 4'(near(cx, 15)),
                             coin(60));
               end else begin
                  put_cell(4'(near(cx, 15)), 8'(near(cy, 255)), 4'(near(cz, 15)),
                           coin(60));
               end
            end
            query_cell(4'(near(cx, 15)), 8'(near(cy, 255)), 4'(near(cz, 15)));
         end else begin
            case ($urandom_range(0, 3))
               0: put_cell(4'($urandom), 8'($urandom), 4'($urandom), coin(50));
               1: put_border(2'($urandom), 8'($urandom), 4'($urandom), coin(50));
               2: begin
                  item = vfc_req_type'($urandom);
                  item.req_type = REQ_UNUSED;
                  send_item(item);
               end
               default: query_cell(4'($urandom), 8'($urandom), 4'($urandom));
            endcase
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      burst_left = 0;
      max_gap = 3;
      items_sent = 0;
      repeat (9) @(negedge clock);
      reset = 1'b0;

      csr_write(NEIGHBOUR_ADDR, 32'h0);
      // nothing lives at this address, the mask must stay clear
      csr_write(SPARE_ADDR, 32'hF);

      // lone cell, then covered above, then fully enclosed
      put_cell(4'd5, 8'd100, 4'd7, 1'b1);
      surround(4'd5, 8'd100, 4'd7, 1'b0);
      query_cell(4'd5, 8'd100, 4'd7);
      put_cell(4'd5, 8'd101, 4'd7, 1'b1);
      query_cell(4'd5, 8'd100, 4'd7);
      surround(4'd5, 8'd100, 4'd7, 1'b1);
      query_cell(4'd5, 8'd100, 4'd7);

      // chunk corners with solid borders but no neighbours present
      put_cell(4'd0, 8'd0, 4'd0, 1'b1);
      put_border(SIDE_LEFT, 8'd0, 4'd0, 1'b1);
      put_border(SIDE_BACK, 8'd0, 4'd0, 1'b1);
      query_cell(4'd0, 8'd0, 4'd0);
      put_cell(4'd15, 8'd255, 4'd15, 1'b1);
      put_cell(4'd15, 8'd0, 4'd15, 1'b1);
      put_border(SIDE_RIGHT, 8'd255, 4'd15, 1'b1);
      put_border(SIDE_FORWARD, 8'd255, 4'd15, 1'b1);
      query_cell(4'd15, 8'd255, 4'd15);

      // air cell and the unused request kind
      put_cell(4'd3, 8'd77, 4'd12, 1'b0);
      query_cell(4'd3, 8'd77, 4'd12);
      send_item(vfc_req_type'({REQ_UNUSED, 23'h7FFFFF}));

      // all neighbours present: side edges now covered, top and bottom stay open
      settle();
      csr_write(NEIGHBOUR_ADDR, 32'hF);
      query_cell(4'd0, 8'd0, 4'd0);
      query_cell(4'd15, 8'd255, 4'd15);

      run_phase(4'h0, 60);
      run_phase(4'hF, 60);
      run_phase(4'($urandom), 60);
      run_phase(4'h5, 60);
      run_phase(4'hA, 60);
      run_phase(4'($urandom), 60);

      settle();
      if (faces.errors == 0 && faces.faces_due.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
